// ===== hw/rtl/pbd_pkg.sv =====
// pbd_pkg: shared types and constants for the packbits segment decoder
// no dependencies; imported by every module of the decoder
package pbd_pkg;

    localparam int unsigned CNT_W     = 25;
    localparam int unsigned BYTE_W    = 8;
    localparam logic [CNT_W-1:0] SEG_BYTES_RESET = 25'd262144;
    localparam logic [BYTE_W-1:0] HDR_LIT_MAX = 8'd127;
    localparam logic [BYTE_W-1:0] HDR_NOP     = 8'd128;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_REPEAT  = 2'd2
    } t_mode;

    // one decoded run piece: a byte repeated len times
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] len;
        logic              run_end;
    } t_job;

endpackage

// ===== hw/rtl/pbd_parse.sv =====
// pbd_parse: header/literal/repeat state machine of the packbits decoder
// depends on pbd_pkg; turns each accepted byte into an optional job
module pbd_parse (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  logic [pbd_pkg::BYTE_W-1:0] i_byte,
    output logic                      o_job_valid,
    output pbd_pkg::t_job             o_job
);
    import pbd_pkg::*;

    t_mode             r_mode, n_mode;
    logic [BYTE_W-1:0] r_lit, n_lit;
    logic [BYTE_W-1:0] r_rep, n_rep;
    logic [BYTE_W-1:0] lit_dec;

    assign lit_dec = (r_lit != '0) ? r_lit - 8'd1 : r_lit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEADER;
            r_lit  <= '0;
            r_rep  <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_lit  <= n_lit;
            r_rep  <= n_rep;
        end
    end

    // next state
    always_comb begin
        n_mode = MODE_HEADER;
        n_lit  = r_lit;
        n_rep  = r_rep;
        unique case (r_mode)
            MODE_LITERAL: begin
                n_lit  = lit_dec;
                n_mode = (lit_dec == '0) ? MODE_HEADER : MODE_LITERAL;
            end
            MODE_REPEAT: begin
                n_rep  = '0;
                n_mode = MODE_HEADER;
            end
            default: begin
                if (i_byte <= HDR_LIT_MAX) begin
                    n_lit  = i_byte + 8'd1;
                    n_mode = MODE_LITERAL;
                end else if (i_byte != HDR_NOP) begin
                    n_rep  = 8'd1 - i_byte;
                    n_mode = MODE_REPEAT;
                end
            end
        endcase
    end

    // job output
    always_comb begin
        o_job_valid   = 1'b0;
        o_job.data    = i_byte;
        o_job.len     = 8'd1;
        o_job.run_end = 1'b1;
        unique case (r_mode)
            MODE_LITERAL: begin
                o_job_valid   = i_take;
                o_job.run_end = (lit_dec == '0);
            end
            MODE_REPEAT: begin
                o_job_valid = i_take;
                o_job.len   = r_rep;
            end
            default: begin
                o_job_valid = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pbd_emit.sv =====
// pbd_emit: job register, two-byte burst emitter, segment counter, output register
// depends on pbd_pkg; fed by pbd_parse
module pbd_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pbd_pkg::CNT_W-1:0]  i_seg_bytes,
    input  logic                       i_job_valid,
    input  pbd_pkg::t_job              i_job,
    output logic                       o_job_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [pbd_pkg::BYTE_W-1:0] o_out_byte_a,
    output logic [pbd_pkg::BYTE_W-1:0] o_out_byte_b,
    output logic [1:0]                 o_byte_count,
    output logic                       o_run_last,
    output logic                       o_segment_end
);
    import pbd_pkg::*;

    logic              r_busy;
    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] r_left;
    logic              r_run_end;
    logic [CNT_W-1:0]  r_done, n_done;
    logic              r_ov;
    logic [BYTE_W-1:0] r_a, r_b;
    logic [1:0]        r_cnt;
    logic              r_last, r_end;

    logic              adv, two, last, hit;
    logic [1:0]        chunk;
    logic [CNT_W:0]    sum;
    logic [CNT_W-1:0]  sat, lim;

    assign adv   = r_busy && (!r_ov || i_out_ready);
    assign two   = (r_left >= 8'd2);
    assign last  = (r_left <= 8'd2);
    assign chunk = two ? 2'd2 : 2'd1;
    assign sum   = {1'b0, r_done} + {{(CNT_W-1){1'b0}}, chunk};
    assign sat   = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    assign lim   = (i_seg_bytes == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : i_seg_bytes;
    assign hit   = last && r_run_end && (sat >= lim);
    assign n_done = hit ? '0 : sat;

    assign o_job_ready = !r_busy || (adv && last);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_done <= '0;
        end else begin
            if (i_job_valid && o_job_ready) begin
                r_busy <= 1'b1;
            end else if (adv && last) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_ov   <= 1'b1;
                r_done <= n_done;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_job_valid && o_job_ready) begin
            r_data    <= i_job.data;
            r_left    <= i_job.len;
            r_run_end <= i_job.run_end;
        end else if (adv) begin
            r_left <= r_left - {6'd0, chunk};
        end
        if (adv) begin
            r_a    <= r_data;
            r_b    <= two ? r_data : '0;
            r_cnt  <= chunk;
            r_last <= last;
            r_end  <= hit;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte_a  = r_a;
    assign o_out_byte_b  = r_b;
    assign o_byte_count  = r_cnt;
    assign o_run_last    = r_last;
    assign o_segment_end = r_end;

endmodule

// ===== hw/rtl/packbits_segment_decoder.sv =====
// PackBits segment decoder. One compressed byte is taken per request; literal
// bytes each give one result a cycle with the output ready, so a literal
// stream runs at one byte per clock while the output is ready. A repeat byte
// of length L gives ceil(L/2) results, one per cycle with the output ready,
// each of two bytes except a final single byte when L is odd. The input is
// held off until the last result and taken again in the cycle it is registered.
// Header bytes give no result; results pass through the job register and the
// output register. The user must write the segment size register only while
// the block is idle (not enforced by the block); a size of zero acts as one.
// depends on pbd_pkg, pbd_parse, pbd_emit
module packbits_segment_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pbd_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [pbd_pkg::BYTE_W-1:0] i_in_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [pbd_pkg::BYTE_W-1:0] o_out_byte_a,
    output logic [pbd_pkg::BYTE_W-1:0] o_out_byte_b,
    output logic [1:0]                 o_byte_count,
    output logic                       o_run_last,
    output logic                       o_segment_end
);
    import pbd_pkg::*;

    logic [CNT_W-1:0] r_seg_bytes;
    logic             take;
    logic             job_valid;
    logic             job_ready;
    t_job             job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_bytes <= SEG_BYTES_RESET;
        end else if (i_cfg_we) begin
            r_seg_bytes <= i_cfg_wdata;
        end
    end

    assign o_in_ready = job_ready;
    assign take       = i_in_valid && job_ready;

    pbd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_in_byte),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    pbd_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seg_bytes   (r_seg_bytes),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .o_job_ready   (job_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte_a  (o_out_byte_a),
        .o_out_byte_b  (o_out_byte_b),
        .o_byte_count  (o_byte_count),
        .o_run_last    (o_run_last),
        .o_segment_end (o_segment_end)
    );

endmodule
